@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, sampled on clk, off while in reset.
`define LCDT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lcdt_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdt_pkg
// Types and constants for the LCD timing and register controller.
// ----------------------------------------------------------------------------
package lcdt_pkg;

    localparam int unsigned DOTS_PER_LINE   = 456;
    localparam int unsigned VISIBLE_LINES   = 144;
    localparam int unsigned LINES_PER_FRAME = 154;
    localparam int unsigned OAM_BYTES       = 160;

    localparam int unsigned DOT_W = 9;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    localparam logic [3:0] REG_LCDC = 4'd0;
    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_SCY  = 4'd2;
    localparam logic [3:0] REG_SCX  = 4'd3;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;
    localparam logic [3:0] REG_DMA  = 4'd6;
    localparam logic [3:0] REG_BGP  = 4'd7;
    localparam logic [3:0] REG_OBP0 = 4'd8;
    localparam logic [3:0] REG_OBP1 = 4'd9;
    localparam logic [3:0] REG_WY   = 4'd10;
    localparam logic [3:0] REG_WX   = 4'd11;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam int unsigned LCDC_ENABLE   = 7;
    localparam int unsigned LCDC_WIN_EN   = 5;
    localparam int unsigned STAT_LYC_FLAG = 2;
    localparam int unsigned STAT_HBL_IE   = 3;
    localparam int unsigned STAT_VBL_IE   = 4;
    localparam int unsigned STAT_OAM_IE   = 5;
    localparam int unsigned STAT_LYC_IE   = 6;

    localparam logic [7:0] STAT_WR_MASK  = 8'hF8;
    localparam logic [7:0] STAT_OFF_MASK = 8'h7C;
    localparam logic [7:0] WX_MAX        = 8'd166;
    localparam logic [DOT_W-1:0] OAM_SCAN_DOTS = DOT_W'(80);

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] STAT_RESET = 8'h02;
    localparam logic [7:0] BGP_RESET  = 8'hFC;
    localparam logic [7:0] OBP_RESET  = 8'hFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] register_index;
        logic [7:0] write_data;
        logic       machine_cycle_edge;
        logic       drawing_done;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        vblank_irq;
        logic        stat_irq;
        logic        dma_copy_valid;
        logic [15:0] dma_source_address;
        logic [7:0]  dma_oam_index;
        logic [1:0]  display_mode;
        logic [7:0]  current_line;
        logic [7:0]  window_line_out;
        logic        frame_buffer_select;
    } result_t;

endpackage

@@ hdl/lcdt_in_stage.sv @@
// ----------------------------------------------------------------------------
// lcdt_in_stage
// Input register: holds one accepted transaction for the step logic.
// ----------------------------------------------------------------------------
module lcdt_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic           take,
    input  lcdt_pkg::item_t item,
    output logic           hold_valid,
    output lcdt_pkg::item_t hold_item
);
    import lcdt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign valid_next = load | (valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

@@ hdl/lcdt_engine.sv @@
// ----------------------------------------------------------------------------
// lcdt_engine
// Register file, line/mode timing and OAM DMA; one step per transaction.
// ----------------------------------------------------------------------------
module lcdt_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  lcdt_pkg::item_t   item,
    output lcdt_pkg::result_t result
);
    import lcdt_pkg::*;

    logic [7:0]       lcdc_reg, lcdc_next;
    logic [7:0]       stat_reg, stat_next;
    logic [7:0]       scy_reg, scy_next;
    logic [7:0]       scx_reg, scx_next;
    logic [7:0]       ly_reg, ly_next;
    logic [7:0]       lyc_reg, lyc_next;
    logic [7:0]       dma_page_reg, dma_page_next;
    logic [7:0]       bgp_reg, bgp_next;
    logic [7:0]       obp0_reg, obp0_next;
    logic [7:0]       obp1_reg, obp1_next;
    logic [7:0]       wy_reg, wy_next;
    logic [7:0]       wx_reg, wx_next;
    logic [7:0]       win_line_reg, win_line_next;
    logic [DOT_W-1:0] dot_reg, dot_next;
    logic             dma_busy_reg, dma_busy_next;
    logic [7:0]       dma_index_reg, dma_index_next;
    logic             dma_wait_reg, dma_wait_next;
    logic             back_buffer_reg, back_buffer_next;

    logic [DOT_W-1:0] dot_inc;
    logic [7:0]       ly_inc;
    logic [8:0]       dma_index_inc;
    logic [8:0]       win_end;
    logic             win_on;
    logic             win_adv;
    logic             lyc_hit;
    logic             line_end;
    result_t          res;

    assign dot_inc       = dot_reg + DOT_W'(1);
    assign ly_inc        = ly_reg + 8'd1;
    assign dma_index_inc = {1'b0, dma_index_reg} + 9'd1;
    assign win_end       = {1'b0, wy_reg} + 9'(VISIBLE_LINES);
    assign win_on        = lcdc_reg[LCDC_WIN_EN] && (wx_reg <= WX_MAX)
                           && (wy_reg < 8'(VISIBLE_LINES));
    assign win_adv       = win_on && (ly_reg >= wy_reg) && ({1'b0, ly_reg} < win_end);
    assign lyc_hit       = (ly_inc == lyc_reg);
    assign line_end      = (dot_inc >= DOT_W'(DOTS_PER_LINE));

    always_comb
    begin
        lcdc_next        = lcdc_reg;
        stat_next        = stat_reg;
        scy_next         = scy_reg;
        scx_next         = scx_reg;
        ly_next          = ly_reg;
        lyc_next         = lyc_reg;
        dma_page_next    = dma_page_reg;
        bgp_next         = bgp_reg;
        obp0_next        = obp0_reg;
        obp1_next        = obp1_reg;
        wy_next          = wy_reg;
        wx_next          = wx_reg;
        win_line_next    = win_line_reg;
        dot_next         = dot_reg;
        dma_busy_next    = dma_busy_reg;
        dma_index_next   = dma_index_reg;
        dma_wait_next    = dma_wait_reg;
        back_buffer_next = back_buffer_reg;
        res              = '0;

        if (fire)
        begin
            case (op_t'(item.operation))
                OP_READ:
                begin
                    case (item.register_index)
                        REG_LCDC: res.read_data = lcdc_reg;
                        REG_STAT: res.read_data = stat_reg;
                        REG_SCY:  res.read_data = scy_reg;
                        REG_SCX:  res.read_data = scx_reg;
                        REG_LY:   res.read_data = ly_reg;
                        REG_LYC:  res.read_data = lyc_reg;
                        REG_DMA:  res.read_data = dma_page_reg;
                        REG_BGP:  res.read_data = bgp_reg;
                        REG_OBP0: res.read_data = obp0_reg;
                        REG_OBP1: res.read_data = obp1_reg;
                        REG_WY:   res.read_data = wy_reg;
                        REG_WX:   res.read_data = wx_reg;
                        default:  res.read_data = 8'd0;
                    endcase
                end
                OP_WRITE:
                begin
                    case (item.register_index)
                        REG_LCDC:
                        begin
                            if (lcdc_reg[LCDC_ENABLE] && !item.write_data[LCDC_ENABLE])
                            begin
                                stat_next     = stat_reg & STAT_OFF_MASK;
                                ly_next       = 8'd0;
                                win_line_next = 8'd0;
                                dot_next      = '0;
                            end
                            lcdc_next = item.write_data;
                        end
                        REG_STAT:
                            stat_next = (stat_reg & ~STAT_WR_MASK)
                                        | (item.write_data & STAT_WR_MASK);
                        REG_SCY:  scy_next = item.write_data;
                        REG_SCX:  scx_next = item.write_data;
                        REG_LYC:  lyc_next = item.write_data;
                        REG_DMA:
                        begin
                            dma_busy_next  = 1'b1;
                            dma_index_next = 8'd0;
                            dma_wait_next  = 1'b1;
                            dma_page_next  = item.write_data;
                        end
                        REG_BGP:  bgp_next  = item.write_data;
                        REG_OBP0: obp0_next = item.write_data;
                        REG_OBP1: obp1_next = item.write_data;
                        REG_WY:   wy_next   = item.write_data;
                        REG_WX:   wx_next   = item.write_data;
                        default:  ;
                    endcase
                end
                OP_TICK:
                begin
                    if (item.machine_cycle_edge && dma_busy_reg)
                    begin
                        if (dma_wait_reg)
                        begin
                            dma_wait_next = 1'b0;
                        end
                        else
                        begin
                            res.dma_copy_valid     = 1'b1;
                            res.dma_source_address = {dma_page_reg, dma_index_reg};
                            res.dma_oam_index      = dma_index_reg;
                            dma_index_next         = dma_index_inc[7:0];
                            dma_busy_next          = (dma_index_inc < 9'(OAM_BYTES));
                        end
                    end
                    if (lcdc_reg[LCDC_ENABLE])
                    begin
                        dot_next = dot_inc;
                        case (stat_reg[1:0])
                            MODE_OAM:
                            begin
                                if (dot_inc >= OAM_SCAN_DOTS)
                                begin
                                    stat_next[1:0] = MODE_DRAW;
                                end
                            end
                            MODE_DRAW:
                            begin
                                if (!dot_inc[0] && item.drawing_done)
                                begin
                                    stat_next[1:0] = MODE_HBLANK;
                                    res.stat_irq   = stat_reg[STAT_HBL_IE];
                                end
                            end
                            default:
                            begin
                                if (line_end)
                                begin
                                    if (win_adv)
                                    begin
                                        win_line_next = win_line_reg + 8'd1;
                                    end
                                    ly_next                  = ly_inc;
                                    stat_next[STAT_LYC_FLAG] = lyc_hit;
                                    res.stat_irq = lyc_hit && stat_reg[STAT_LYC_IE];
                                    dot_next     = '0;
                                    if (stat_reg[1:0] == MODE_HBLANK)
                                    begin
                                        if (ly_inc >= 8'(VISIBLE_LINES))
                                        begin
                                            stat_next[1:0]   = MODE_VBLANK;
                                            res.vblank_irq   = 1'b1;
                                            back_buffer_next = ~back_buffer_reg;
                                            if (stat_reg[STAT_VBL_IE])
                                            begin
                                                res.stat_irq = 1'b1;
                                            end
                                        end
                                        else
                                        begin
                                            stat_next[1:0] = MODE_OAM;
                                            if (stat_reg[STAT_OAM_IE])
                                            begin
                                                res.stat_irq = 1'b1;
                                            end
                                        end
                                    end
                                    else if (ly_inc >= 8'(LINES_PER_FRAME))
                                    begin
                                        stat_next[1:0] = MODE_OAM;
                                        ly_next        = 8'd0;
                                        win_line_next  = 8'd0;
                                        if (stat_reg[STAT_OAM_IE])
                                        begin
                                            res.stat_irq = 1'b1;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end

        res.display_mode        = stat_next[1:0];
        res.current_line        = ly_next;
        res.window_line_out     = win_line_next;
        res.frame_buffer_select = back_buffer_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg        <= LCDC_RESET;
            stat_reg        <= STAT_RESET;
            scy_reg         <= 8'd0;
            scx_reg         <= 8'd0;
            ly_reg          <= 8'd0;
            lyc_reg         <= 8'd0;
            dma_page_reg    <= 8'd0;
            bgp_reg         <= BGP_RESET;
            obp0_reg        <= OBP_RESET;
            obp1_reg        <= OBP_RESET;
            wy_reg          <= 8'd0;
            wx_reg          <= 8'd0;
            win_line_reg    <= 8'd0;
            dot_reg         <= '0;
            dma_busy_reg    <= 1'b0;
            dma_index_reg   <= 8'd0;
            dma_wait_reg    <= 1'b0;
            back_buffer_reg <= 1'b0;
        end
        else
        begin
            lcdc_reg        <= lcdc_next;
            stat_reg        <= stat_next;
            scy_reg         <= scy_next;
            scx_reg         <= scx_next;
            ly_reg          <= ly_next;
            lyc_reg         <= lyc_next;
            dma_page_reg    <= dma_page_next;
            bgp_reg         <= bgp_next;
            obp0_reg        <= obp0_next;
            obp1_reg        <= obp1_next;
            wy_reg          <= wy_next;
            wx_reg          <= wx_next;
            win_line_reg    <= win_line_next;
            dot_reg         <= dot_next;
            dma_busy_reg    <= dma_busy_next;
            dma_index_reg   <= dma_index_next;
            dma_wait_reg    <= dma_wait_next;
            back_buffer_reg <= back_buffer_next;
        end
    end

    assign result = res;

endmodule

@@ hdl/lcdt_out_stage.sv @@
// ----------------------------------------------------------------------------
// lcdt_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module lcdt_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             take,
    input  lcdt_pkg::result_t res_in,
    output logic             hold_valid,
    output lcdt_pkg::result_t res_out
);
    import lcdt_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign valid_next = load | (valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign hold_valid = valid_reg;
    assign res_out    = res_reg;

endmodule

@@ hdl/lcd_timing_register_controller_core.sv @@
// ----------------------------------------------------------------------------
// lcd_timing_register_controller_core
// LCD register file, dot/line/mode timing and OAM DMA, one item per clock unless result_ready stalls.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input reg, then its result in the result reg.
// Throughput: 1 item per cycle while result_ready is high; the single step of the state update sets it.
// Reset: rst_n async; registers take their power-on values, both stages empty.
// ----------------------------------------------------------------------------
module lcd_timing_register_controller_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [3:0]  register_index,
    input  logic [7:0]  write_data,
    input  logic        machine_cycle_edge,
    input  logic        drawing_done,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  read_data,
    output logic        vblank_irq,
    output logic        stat_irq,
    output logic        dma_copy_valid,
    output logic [15:0] dma_source_address,
    output logic [7:0]  dma_oam_index,
    output logic [1:0]  display_mode,
    output logic [7:0]  current_line,
    output logic [7:0]  window_line_out,
    output logic        frame_buffer_select
);
    import lcdt_pkg::*;

    item_t   item_in;
    item_t   item_held;
    logic    held_valid;
    logic    advance;
    logic    item_fire;
    result_t step_res;
    result_t res_held;

    assign item_in.operation          = operation;
    assign item_in.register_index     = register_index;
    assign item_in.write_data         = write_data;
    assign item_in.machine_cycle_edge = machine_cycle_edge;
    assign item_in.drawing_done       = drawing_done;

    assign advance    = held_valid && (!result_valid || result_ready);
    assign item_ready = !held_valid || advance;
    assign item_fire  = item_valid && item_ready;

    lcdt_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (item_fire),
        .take       (advance),
        .item       (item_in),
        .hold_valid (held_valid),
        .hold_item  (item_held)
    );

    lcdt_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_held),
        .result (step_res)
    );

    lcdt_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .take       (result_ready),
        .res_in     (step_res),
        .hold_valid (result_valid),
        .res_out    (res_held)
    );

    assign read_data           = res_held.read_data;
    assign vblank_irq          = res_held.vblank_irq;
    assign stat_irq            = res_held.stat_irq;
    assign dma_copy_valid      = res_held.dma_copy_valid;
    assign dma_source_address  = res_held.dma_source_address;
    assign dma_oam_index       = res_held.dma_oam_index;
    assign display_mode        = res_held.display_mode;
    assign current_line        = res_held.current_line;
    assign window_line_out     = res_held.window_line_out;
    assign frame_buffer_select = res_held.frame_buffer_select;

endmodule

@@ hdl/lcdt_checker.sv @@
// ----------------------------------------------------------------------------
// lcdt_checker
// Port-level checks on the controller core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [7:0]  read_data,
    input logic        vblank_irq,
    input logic        dma_copy_valid,
    input logic [15:0] dma_source_address,
    input logic [7:0]  dma_oam_index,
    input logic [1:0]  display_mode,
    input logic [7:0]  current_line
);
    import lcdt_pkg::*;

    `LCDT_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid, "result transaction dropped before acceptance")
    `LCDT_ASSERT(a_ready_when_empty, !result_valid |-> item_ready, "input stalled while result side is empty")
    `LCDT_ASSERT(a_vblank_entry, result_valid && vblank_irq |-> display_mode == MODE_VBLANK && current_line == 8'(VISIBLE_LINES), "vblank pulse outside vblank entry")
    `LCDT_ASSERT(a_dma_index_range, result_valid && dma_copy_valid |-> dma_oam_index < 8'(OAM_BYTES - 1) + 8'd1 && dma_source_address[7:0] == dma_oam_index, "DMA copy index out of range")
    `LCDT_ASSERT(a_read_quiet, result_valid && read_data != 8'd0 |-> !dma_copy_valid && !vblank_irq, "read transaction also reports tick activity")

endmodule

bind lcd_timing_register_controller_core lcdt_checker u_lcdt_checker (.*);
